// File: hdl/vssp_pkg.sv
// Package for the vertex store with support-point query.
// Holds the function and status codes, the register widths and the control structs.
// Depends on nothing; the cell, evaluation, top-level and testbench files import it.
package vssp_pkg;

    // Width and reset value of the vertex limit register.
    localparam int LIMIT_W = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    // Width of the vertex index field of a result.
    localparam int INDEX_W = 8;

    // Function codes of a command.
    typedef enum logic [1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_ADD_FIND = 2'd1,
        FUNC_QUERY    = 2'd2,
        FUNC_CLEAR    = 2'd3
    } func_t;

    // Status codes of a result.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Control of one storage cell: rotate the ring or load a new point.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Control of the evaluation pipeline: start a new scan, present a live entry.
    typedef struct packed {
        logic start;
        logic issue;
    } scan_ctrl_t;

endpackage

// File: hdl/vssp_if.sv
// Handshake channel interfaces for the vertex store: command in, result out.
// Each carries valid, ready and the payload; a transfer happens when both are high.
// Depends on nothing.
interface vssp_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source (output valid, output func, output coord_x, output coord_y,
                    output coord_z, input ready);
    modport sink   (input valid, input func, input coord_x, input coord_y,
                    input coord_z, output ready);
endinterface

interface vssp_out_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [7:0]                   vertex_index;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;

    modport source (output valid, output status, output vertex_index, output point_x,
                    output point_y, output point_z, input ready);
    modport sink   (input valid, input status, input vertex_index, input point_x,
                    input point_y, input point_z, output ready);
endinterface

// File: hdl/vssp_cell.sv
// One storage cell of the vertex ring: holds a single packed point {x, y, z}.
// It either takes its neighbor's point (ring rotation), loads a new point, or holds.
// Depends on vssp_pkg for the cell control struct.
module vssp_cell #(
    parameter int PT_W = 72
) (
    input  logic                   clk,
    input  vssp_pkg::cell_ctrl_t   ctrl,
    input  logic [PT_W-1:0]        nbr,
    input  logic [PT_W-1:0]        wdata,
    output logic [PT_W-1:0]        q
);
    import vssp_pkg::*;

    logic [PT_W-1:0] pt_reg;
    logic [PT_W-1:0] pt_next;

    // Rotation wins over a load; the controller never asks for both.
    always_comb
    begin
        pt_next = pt_reg;
        if (ctrl.shift)
        begin
            pt_next = nbr;
        end
        else if (ctrl.load)
        begin
            pt_next = wdata;
        end
    end

    // Point storage; its contents are undefined until written.
    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    assign q = pt_reg;

endmodule

// File: hdl/vssp_eval.sv
// Evaluation pipeline fed by the head of the vertex ring, one entry per cycle.
// Stage one forms the three exact products and the equality match; stage two sums,
// compares against the running best and records the first match.
// Depends on vssp_pkg for the scan control struct.
module vssp_eval #(
    parameter int COORD_BITS = 24,
    parameter int IDX_W      = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  vssp_pkg::scan_ctrl_t      ctrl,
    input  logic [3*COORD_BITS-1:0]   head,
    input  logic [IDX_W-1:0]          head_idx,
    input  logic [3*COORD_BITS-1:0]   key,
    output logic [IDX_W-1:0]          best_idx,
    output logic [3*COORD_BITS-1:0]   best_pt,
    output logic                      found,
    output logic [IDX_W-1:0]          found_idx
);
    import vssp_pkg::*;

    localparam int PT_W   = 3 * COORD_BITS;
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [COORD_BITS-1:0] head_x;
    logic signed [COORD_BITS-1:0] head_y;
    logic signed [COORD_BITS-1:0] head_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;

    // Stage one registers.
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic [PT_W-1:0]          s1_pt_reg;
    logic signed [PROD_W-1:0] s1_px_reg;
    logic signed [PROD_W-1:0] s1_py_reg;
    logic signed [PROD_W-1:0] s1_pz_reg;
    logic signed [PROD_W-1:0] s1_px_next;
    logic signed [PROD_W-1:0] s1_py_next;
    logic signed [PROD_W-1:0] s1_pz_next;
    logic                     s1_match_reg;
    logic                     s1_match_next;

    // Stage two: running best and first match.
    logic signed [SUM_W-1:0]  s1_sum;
    logic                     take_best;
    logic                     take_match;
    logic                     have_best_reg;
    logic                     have_best_next;
    logic signed [SUM_W-1:0]  best_sum_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [PT_W-1:0]          best_pt_reg;
    logic                     found_reg;
    logic                     found_next;
    logic [IDX_W-1:0]         found_idx_reg;

    assign head_x = head[PT_W-1 -: COORD_BITS];
    assign head_y = head[PT_W-COORD_BITS-1 -: COORD_BITS];
    assign head_z = head[COORD_BITS-1:0];
    assign dir_x  = key[PT_W-1 -: COORD_BITS];
    assign dir_y  = key[PT_W-COORD_BITS-1 -: COORD_BITS];
    assign dir_z  = key[COORD_BITS-1:0];

    // Stage one: products against the direction and exact match against the key.
    always_comb
    begin
        s1_valid_next = ctrl.issue;
        s1_px_next    = head_x * dir_x;
        s1_py_next    = head_y * dir_y;
        s1_pz_next    = head_z * dir_z;
        s1_match_next = (head == key);
    end

    // Stage two: the dot product is exact in SUM_W bits; strict compare keeps the
    // lowest index on a tie because entries arrive in ascending order.
    always_comb
    begin
        s1_sum     = SUM_W'(s1_px_reg) + SUM_W'(s1_py_reg) + SUM_W'(s1_pz_reg);
        take_best  = s1_valid_reg && (!have_best_reg || (s1_sum > best_sum_reg));
        take_match = s1_valid_reg && s1_match_reg && !found_reg;

        have_best_next = have_best_reg;
        found_next     = found_reg;
        if (ctrl.start)
        begin
            have_best_next = 1'b0;
            found_next     = 1'b0;
        end
        else
        begin
            if (take_best)
            begin
                have_best_next = 1'b1;
            end
            if (take_match)
            begin
                found_next = 1'b1;
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            have_best_reg <= have_best_next;
            found_reg     <= found_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= head_idx;
        s1_pt_reg    <= head;
        s1_px_reg    <= s1_px_next;
        s1_py_reg    <= s1_py_next;
        s1_pz_reg    <= s1_pz_next;
        s1_match_reg <= s1_match_next;
        if (take_best)
        begin
            best_sum_reg <= s1_sum;
            best_idx_reg <= s1_idx_reg;
            best_pt_reg  <= s1_pt_reg;
        end
        if (take_match)
        begin
            found_idx_reg <= s1_idx_reg;
        end
    end

    assign best_idx  = best_idx_reg;
    assign best_pt   = best_pt_reg;
    assign found     = found_reg;
    assign found_idx = found_idx_reg;

endmodule

// File: hdl/vertex_store_support_point.sv
// Vertex store with support-point query for a convex hull. Points live in a ring of
// RING_DEPTH cells; add-or-find and support query rotate the whole ring once past an
// evaluation pipeline, one entry per cycle, then drain it and resolve the result;
// add-or-find goes on to append when no match is found. Add goes straight to append;
// clear and a query on an empty store skip the scan. One command is worked on at a
// time; the next command is taken while the previous result still waits in the output
// register. Dot products are exact and ties go to the lowest index. The user writes the
// vertex limit via cfg_we/cfg_wdata only while idle; the block leaves this unchecked.
module vertex_store_support_point #(
    parameter int RING_DEPTH = 256,
    parameter int COORD_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vssp_pkg::LIMIT_W-1:0]    cfg_wdata,
    vssp_in_if.sink                         cmd,
    vssp_out_if.source                      rsp
);
    import vssp_pkg::*;

    localparam int PT_W  = 3 * COORD_BITS;
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = IDX_W + 1;
    localparam int FUL_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESOLVE,
        ST_APPEND,
        ST_DONE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [LIMIT_W-1:0]    limit_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      scan_idx_next;
    func_t                 op_func_reg;
    logic [PT_W-1:0]       op_pt_reg;
    status_t               res_status_reg;
    status_t               res_status_next;
    logic [IDX_W-1:0]      res_idx_reg;
    logic [IDX_W-1:0]      res_idx_next;
    logic [PT_W-1:0]       res_pt_reg;
    logic [PT_W-1:0]       res_pt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               out_status_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic [PT_W-1:0]       out_pt_reg;

    logic                  cmd_xfer;
    logic                  out_load;
    logic                  scan_last;
    logic                  store_full;
    logic [PT_W-1:0]       cmd_pt;
    logic [IDX_W+INDEX_W-1:0] res_idx_ext;
    scan_ctrl_t            scan_ctrl;
    logic [PT_W-1:0]       cell_q [RING_DEPTH];
    logic [IDX_W-1:0]      best_idx;
    logic [PT_W-1:0]       best_pt;
    logic                  found;
    logic [IDX_W-1:0]      found_idx;

    assign cmd_pt    = {cmd.coord_x, cmd.coord_y, cmd.coord_z};
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign scan_last = (scan_idx_reg == IDX_W'(RING_DEPTH - 1));
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // The store is full when the count reaches the limit or the physical size.
    assign store_full = (FUL_W'(count_reg) >= FUL_W'(limit_reg))
                     || (count_reg == CNT_W'(RING_DEPTH));

    // Scan control: clear the running best on entry, flag entries below the count.
    always_comb
    begin
        scan_ctrl.start = cmd_xfer && (state_next == ST_SCAN);
        scan_ctrl.issue = (state_reg == ST_SCAN)
                       && (CMP_W'(scan_idx_reg) < CMP_W'(count_reg));
    end

    // Ring of storage cells; cell i takes cell i+1, so the head walks the entries
    // in ascending order and a full rotation brings the ring back home.
    genvar gi;
    generate
        for (gi = 0; gi < RING_DEPTH; gi++)
        begin : g_cell
            cell_ctrl_t cell_ctrl;

            always_comb
            begin
                cell_ctrl.shift = (state_reg == ST_SCAN);
                cell_ctrl.load  = (state_reg == ST_APPEND) && !store_full
                               && (count_reg == CNT_W'(gi));
            end

            vssp_cell #(
                .PT_W (PT_W)
            ) u_cell (
                .clk   (clk),
                .ctrl  (cell_ctrl),
                .nbr   (cell_q[(gi + 1) % RING_DEPTH]),
                .wdata (op_pt_reg),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    vssp_eval #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .head      (cell_q[0]),
        .head_idx  (scan_idx_reg),
        .key       (op_pt_reg),
        .best_idx  (best_idx),
        .best_pt   (best_pt),
        .found     (found),
        .found_idx (found_idx)
    );

    // Command sequencer.
    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_pt_next     = res_pt_reg;

        if (cfg_we)
        begin
            limit_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    case (func_t'(cmd.func))
                        FUNC_ADD:
                        begin
                            state_next = ST_APPEND;
                        end
                        FUNC_ADD_FIND:
                        begin
                            state_next = ST_SCAN;
                        end
                        FUNC_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                                res_idx_next    = '0;
                                res_pt_next     = '0;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = STATUS_OK;
                            res_idx_next    = '0;
                            res_pt_next     = cmd_pt;
                            state_next      = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_last ? '0 : scan_idx_reg + 1'b1;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last entry still sits in stage one of the pipeline.
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (op_func_reg == FUNC_QUERY)
                begin
                    res_status_next = STATUS_OK;
                    res_idx_next    = best_idx;
                    res_pt_next     = best_pt;
                    state_next      = ST_DONE;
                end
                else if (found)
                begin
                    res_status_next = STATUS_OK;
                    res_idx_next    = found_idx;
                    res_pt_next     = op_pt_reg;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                res_pt_next = op_pt_reg;
                if (store_full)
                begin
                    res_status_next = STATUS_FULL;
                    res_idx_next    = '0;
                end
                else
                begin
                    res_status_next = STATUS_OK;
                    res_idx_next    = IDX_W'(count_reg);
                    count_next      = count_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid: drops on a transfer, rises when a result is loaded.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Vertex index is reported modulo 256.
    assign res_idx_ext = {{INDEX_W{1'b0}}, res_idx_reg};

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            op_func_reg <= func_t'(cmd.func);
            op_pt_reg   <= cmd_pt;
        end
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_pt_reg     <= res_pt_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_idx_ext[INDEX_W-1:0];
            out_pt_reg     <= res_pt_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.vertex_index = out_index_reg;
    assign rsp.point_x      = out_pt_reg[PT_W-1 -: COORD_BITS];
    assign rsp.point_y      = out_pt_reg[PT_W-COORD_BITS-1 -: COORD_BITS];
    assign rsp.point_z      = out_pt_reg[COORD_BITS-1:0];

endmodule

// File: tb/tb_vertex_store_support_point.sv
`timescale 1ns / 100ps
// Self-checking testbench for the vertex store with support-point query. Drives commands
// through the handshake channels; checks results against a predictor or fixed answers.
// Depends on vssp_pkg, the channel interfaces in vssp_if.sv and vertex_store_support_point.
module tb_vertex_store_support_point;

    import vssp_pkg::*;

    localparam int MAX_PTS     = 256;
    localparam int CRD_W       = 24;
    localparam int PHASE_ITEMS = 350;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_TAIL  = 300;

    localparam logic signed [CRD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [CRD_W-1:0] COORD_MIN = 24'sh800000;

    // One result as the block should report it.
    typedef struct {
        status_t                 status;
        logic [INDEX_W-1:0]      index;
        logic signed [CRD_W-1:0] px;
        logic signed [CRD_W-1:0] py;
        logic signed [CRD_W-1:0] pz;
    } vertex_result_t;

    // One row of the directed table: a limit write, or a command with an optional fixed answer.
    typedef struct {
        bit                      is_cfg;
        logic [LIMIT_W-1:0]      limit;
        func_t                   func;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
        bit                      typed;
        vertex_result_t          want;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    vssp_in_if  #(.COORD_BITS(CRD_W)) cmd_ch ();
    vssp_out_if #(.COORD_BITS(CRD_W)) rsp_ch ();

    vertex_store_support_point #(
        .RING_DEPTH (MAX_PTS),
        .COORD_BITS (CRD_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    // Predictor state: the stored hull points, their count and the vertex limit.
    logic signed [CRD_W-1:0] hull_x [MAX_PTS];
    logic signed [CRD_W-1:0] hull_y [MAX_PTS];
    logic signed [CRD_W-1:0] hull_z [MAX_PTS];
    int                      hull_count;
    int                      hull_limit;

    vertex_result_t pending_results [$];
    directed_row_t  directed_rows [$];
    vertex_result_t blank_result;

    int error_count  = 0;
    int sent_items   = 0;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int rx_hold_req  = 0;

    always #5 clk = ~clk;

    // Works out the result of one command and updates the predicted store.
    function automatic vertex_result_t predict_vertex(func_t f, logic signed [CRD_W-1:0] x,
                                                      logic signed [CRD_W-1:0] y,
                                                      logic signed [CRD_W-1:0] z);
        vertex_result_t r;
        int             hit;
        int             cap;
        int             best;
        longint         dot;
        longint         best_dot;
        r.status = STATUS_OK;
        r.index  = '0;
        r.px     = x;
        r.py     = y;
        r.pz     = z;
        cap      = (hull_limit < MAX_PTS) ? hull_limit : MAX_PTS;
        best_dot = 0;
        case (f)
            FUNC_ADD, FUNC_ADD_FIND:
            begin
                hit = -1;
                if (f == FUNC_ADD_FIND)
                begin
                    for (int i = 0; i < hull_count; i++)
                    begin
                        if (hit < 0 && hull_x[i] == x && hull_y[i] == y && hull_z[i] == z)
                            hit = i;
                    end
                end
                if (hit >= 0)
                begin
                    r.index = INDEX_W'(hit);
                end
                else if (hull_count >= cap)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    hull_x[hull_count] = x;
                    hull_y[hull_count] = y;
                    hull_z[hull_count] = z;
                    r.index = INDEX_W'(hull_count);
                    hull_count++;
                end
            end
            FUNC_QUERY:
            begin
                if (hull_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                    r.px = '0;
                    r.py = '0;
                    r.pz = '0;
                end
                else
                begin
                    // Exact dot products; a later point must be strictly greater to win.
                    best = 0;
                    for (int i = 0; i < hull_count; i++)
                    begin
                        dot = longint'(hull_x[i]) * longint'(x) + longint'(hull_y[i]) * longint'(y)
                            + longint'(hull_z[i]) * longint'(z);
                        if (i == 0 || dot > best_dot)
                        begin
                            best_dot = dot;
                            best     = i;
                        end
                    end
                    r.index = INDEX_W'(best);
                    r.px    = hull_x[best];
                    r.py    = hull_y[best];
                    r.pz    = hull_z[best];
                end
            end
            default:
            begin
                hull_count = 0;
            end
        endcase
        return r;
    endfunction

    // Random coordinate: an extreme, a small value for ties and matches, or any 24-bit value.
    function automatic logic signed [CRD_W-1:0] pick_coord();
        int unsigned sel;
        int          small_v;
        sel     = $urandom_range(9);
        small_v = int'($urandom_range(8)) - 4;
        if (sel == 0)
            return COORD_MAX;
        if (sel == 1)
            return COORD_MIN;
        if (sel < 5)
            return CRD_W'(small_v);
        return CRD_W'($urandom);
    endfunction

    function automatic void add_row(func_t f, logic signed [CRD_W-1:0] x,
                                    logic signed [CRD_W-1:0] y, logic signed [CRD_W-1:0] z);
        directed_row_t row;
        row.is_cfg = 1'b0;
        row.limit  = '0;
        row.func   = f;
        row.x      = x;
        row.y      = y;
        row.z      = z;
        row.typed  = 1'b0;
        row.want   = blank_result;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed_row(func_t f, logic signed [CRD_W-1:0] x,
                                          logic signed [CRD_W-1:0] y,
                                          logic signed [CRD_W-1:0] z, status_t s, int idx,
                                          logic signed [CRD_W-1:0] ex,
                                          logic signed [CRD_W-1:0] ey,
                                          logic signed [CRD_W-1:0] ez);
        directed_row_t row;
        row.is_cfg      = 1'b0;
        row.limit       = '0;
        row.func        = f;
        row.x           = x;
        row.y           = y;
        row.z           = z;
        row.typed       = 1'b1;
        row.want.status = s;
        row.want.index  = INDEX_W'(idx);
        row.want.px     = ex;
        row.want.py     = ey;
        row.want.pz     = ez;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(int limit);
        directed_row_t row;
        row.is_cfg = 1'b1;
        row.limit  = LIMIT_W'(limit);
        row.func   = FUNC_ADD;
        row.x      = '0;
        row.y      = '0;
        row.z      = '0;
        row.typed  = 1'b0;
        row.want   = blank_result;
        directed_rows.push_back(row);
    endfunction

    // Offers one command, waits for its transfer and records the expected result.
    task automatic send_cmd(func_t f, logic signed [CRD_W-1:0] x, logic signed [CRD_W-1:0] y,
                            logic signed [CRD_W-1:0] z, bit typed, vertex_result_t given);
        vertex_result_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.func    <= f;
        cmd_ch.coord_x <= x;
        cmd_ch.coord_y <= y;
        cmd_ch.coord_z <= z;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        r = predict_vertex(f, x, y, z);
        pending_results.push_back(typed ? given : r);
        sent_items++;
    endtask

    // Stops offering commands until every expected result has come back.
    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the vertex limit while the block is idle.
    task automatic set_limit(logic [LIMIT_W-1:0] value);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        hull_limit = int'(value);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Result side: checks each transfer and decides ready, with an optional long hold-off.
    initial
    begin
        vertex_result_t want;
        int             hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, status %0d index %0d",
                             $time, rsp_ch.status, rsp_ch.vertex_index);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("vertex_index", want.index, rsp_ch.vertex_index);
                    check_field("point_x", want.px, rsp_ch.point_x);
                    check_field("point_y", want.py, rsp_ch.point_y);
                    check_field("point_z", want.pz, rsp_ch.point_z);
                end
            end
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when work is pending but nothing transfers for too long.
    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (!cmd_ch.valid && pending_results.size() == 0))
                stall = 0;
            else
                stall++;
        end
        $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus: directed table first, then three phases of random hull sequences.
    initial
    begin
        int          phase_start;
        int          cap;
        int          fill_len;
        int          mix_len;
        int          sel;
        int          pick;
        int          new_limit;
        bit          force_fill;
        bit          hold_done;
        func_t       noise_func;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.func    <= FUNC_ADD;
        cmd_ch.coord_x <= '0;
        cmd_ch.coord_y <= '0;
        cmd_ch.coord_z <= '0;

        blank_result.status = STATUS_OK;
        blank_result.index  = '0;
        blank_result.px     = '0;
        blank_result.py     = '0;
        blank_result.pz     = '0;
        hull_count = 0;
        hull_limit = int'(LIMIT_RESET);
        hold_done  = 1'b0;

        // Empty store, extremes, matches, ties and clear at the reset limit.
        add_typed_row(FUNC_QUERY, 1, 2, 3, STATUS_EMPTY, 0, 0, 0, 0);
        add_typed_row(FUNC_ADD, COORD_MAX, COORD_MAX, COORD_MAX, STATUS_OK, 0,
                      COORD_MAX, COORD_MAX, COORD_MAX);
        add_typed_row(FUNC_ADD, COORD_MIN, COORD_MIN, COORD_MIN, STATUS_OK, 1,
                      COORD_MIN, COORD_MIN, COORD_MIN);
        add_typed_row(FUNC_ADD, 0, 0, 0, STATUS_OK, 2, 0, 0, 0);
        add_typed_row(FUNC_ADD_FIND, COORD_MIN, COORD_MIN, COORD_MIN, STATUS_OK, 1,
                      COORD_MIN, COORD_MIN, COORD_MIN);
        add_typed_row(FUNC_ADD_FIND, 1, -1, 2, STATUS_OK, 3, 1, -1, 2);
        add_typed_row(FUNC_QUERY, 1, 1, 1, STATUS_OK, 0, COORD_MAX, COORD_MAX, COORD_MAX);
        add_row(FUNC_QUERY, -1, -1, -1);
        add_row(FUNC_QUERY, 0, 0, 0);
        add_typed_row(FUNC_ADD, COORD_MAX, COORD_MAX, COORD_MAX, STATUS_OK, 4,
                      COORD_MAX, COORD_MAX, COORD_MAX);
        add_row(FUNC_QUERY, COORD_MAX, COORD_MIN, COORD_MAX);
        add_typed_row(FUNC_CLEAR, 5, -6, 7, STATUS_OK, 0, 5, -6, 7);
        add_typed_row(FUNC_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, STATUS_EMPTY, 0, 0, 0, 0);
        add_typed_row(FUNC_ADD_FIND, -1, 0, 1, STATUS_OK, 0, -1, 0, 1);
        add_typed_row(FUNC_ADD, COORD_MIN, COORD_MAX, 0, STATUS_OK, 1, COORD_MIN, COORD_MAX, 0);
        add_row(FUNC_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
        // Zero limit, which is also a limit lowered below the count.
        add_cfg_row(0);
        add_typed_row(FUNC_ADD, 3, 3, 3, STATUS_FULL, 0, 3, 3, 3);
        add_typed_row(FUNC_ADD_FIND, 4, 4, 4, STATUS_FULL, 0, 4, 4, 4);
        add_row(FUNC_ADD_FIND, COORD_MIN, COORD_MAX, 0);
        add_row(FUNC_QUERY, 1, 0, 0);
        // Single-entry store.
        add_cfg_row(1);
        add_typed_row(FUNC_CLEAR, 0, 0, 0, STATUS_OK, 0, 0, 0, 0);
        add_typed_row(FUNC_ADD, COORD_MAX, 0, COORD_MIN, STATUS_OK, 0, COORD_MAX, 0, COORD_MIN);
        add_typed_row(FUNC_ADD, 1, 1, 1, STATUS_FULL, 0, 1, 1, 1);
        add_row(FUNC_ADD_FIND, COORD_MAX, 0, COORD_MIN);
        add_row(FUNC_QUERY, 0, -1, 0);
        add_cfg_row(511);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 7;
        dst_idle_pct = 46;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                set_limit(directed_rows[i].limit);
            else
                send_cmd(directed_rows[i].func, directed_rows[i].x, directed_rows[i].y,
                         directed_rows[i].z, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 7;
                    dst_idle_pct = 46;
                end
                1:
                begin
                    src_idle_pct = 46;
                    dst_idle_pct = 7;
                end
                default:
                begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            phase_start = sent_items;
            // The last phase fills the whole store once so queries scan every entry.
            force_fill  = (phase == 2);
            while (sent_items - phase_start < PHASE_ITEMS)
            begin
                // Sometimes pick a new limit before the next sequence.
                if (force_fill || $urandom_range(3) == 0)
                begin
                    case ($urandom_range(7))
                        0: new_limit = 0;
                        1: new_limit = 1;
                        2: new_limit = 2;
                        3: new_limit = 4;
                        4: new_limit = 255;
                        5: new_limit = 256;
                        6: new_limit = 511;
                        default: new_limit = $urandom_range(300, 3);
                    endcase
                    if (force_fill)
                        new_limit = 511;
                    set_limit(LIMIT_W'(new_limit));
                end

                // A sequence usually opens with a clear, then builds up a set of points.
                if (force_fill || $urandom_range(19) != 0)
                    send_cmd(FUNC_CLEAR, pick_coord(), pick_coord(), pick_coord(), 1'b0,
                             blank_result);
                cap = (hull_limit < MAX_PTS) ? hull_limit : MAX_PTS;
                if (force_fill || $urandom_range(19) == 0)
                    fill_len = cap + 2;
                else
                    fill_len = $urandom_range(12);
                for (int k = 0; k < fill_len; k++)
                    send_cmd(FUNC_ADD, pick_coord(), pick_coord(), pick_coord(), 1'b0,
                             blank_result);
                force_fill = 1'b0;

                // Limit lowered below the count, or a plain pause until the block drains.
                if ($urandom_range(4) == 0)
                    set_limit(LIMIT_W'($urandom_range(hull_count)));
                else if ($urandom_range(3) == 0)
                    wait_results_drained();

                // Long receiver hold-off while the mixed traffic below keeps offering
                // commands, so the block backs up into its input.
                if (phase == 0 && !hold_done)
                begin
                    rx_hold_req = HOLD_CYCLES;
                    hold_done   = 1'b1;
                end

                // Mixed traffic on the built store.
                mix_len = $urandom_range(30, 8);
                for (int k = 0; k < mix_len; k++)
                begin
                    sel = $urandom_range(99);
                    if (sel < 40)
                    begin
                        if (hull_count > 0 && $urandom_range(9) < 7)
                        begin
                            pick = $urandom_range(hull_count - 1);
                            send_cmd(FUNC_ADD_FIND, hull_x[pick], hull_y[pick], hull_z[pick],
                                     1'b0, blank_result);
                        end
                        else
                        begin
                            send_cmd(FUNC_ADD_FIND, pick_coord(), pick_coord(), pick_coord(),
                                     1'b0, blank_result);
                        end
                    end
                    else if (sel < 75)
                    begin
                        send_cmd(FUNC_QUERY, pick_coord(), pick_coord(), pick_coord(), 1'b0,
                                 blank_result);
                    end
                    else if (sel < 90)
                    begin
                        send_cmd(FUNC_ADD, pick_coord(), pick_coord(), pick_coord(), 1'b0,
                                 blank_result);
                    end
                    else if (sel < 95)
                    begin
                        send_cmd(FUNC_CLEAR, pick_coord(), pick_coord(), pick_coord(), 1'b0,
                                 blank_result);
                    end
                    else
                    begin
                        noise_func = func_t'($urandom_range(3));
                        send_cmd(noise_func, CRD_W'($urandom), CRD_W'($urandom),
                                 CRD_W'($urandom), 1'b0, blank_result);
                    end
                end
            end
        end

        // Let every result come back, then watch for stray ones.
        wait_results_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (pending_results.size() > 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time,
                     pending_results.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
